FILE: rtl/core/urte_pkg.sv
// ----------------------------------------------------------------------------
// urte_pkg
// Shared types and constants for the register-link transaction engine.
// ----------------------------------------------------------------------------
package urte_pkg;

  // Frame and reply constants
  localparam logic [7:0]  SYNC_BYTE = 8'hFE;
  localparam logic [15:0] FAIL_DATA = 16'hFFFF;

  // Input operation codes
  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // Result kind codes
  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Status codes
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  // Job queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic {
    JOB_FRAME = 1'b0,
    JOB_DONE  = 1'b1
  } job_kind_t;

  // One unit of work for the back end: a whole frame or one finished result
  typedef struct packed {
    job_kind_t   kind;
    logic        is_read;
    logic [7:0]  addr;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  chk;
    logic [15:0] read_data;
    logic        status;
  } job_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
    logic [QCW-1:0] count;
  } q_stat_t;

endpackage

FILE: rtl/core/urte_in_if.sv
// ----------------------------------------------------------------------------
// urte_in_if
// Input channel: commands and received link bytes, valid/ready handshake.
// ----------------------------------------------------------------------------
interface urte_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic        is_read;
  logic [6:0]  reg_address;
  logic [15:0] write_value;
  logic [7:0]  rx_byte;

  modport source (output valid, op, is_read, reg_address, write_value, rx_byte,
                  input ready);
  modport sink   (input valid, op, is_read, reg_address, write_value, rx_byte,
                  output ready);
endinterface

FILE: rtl/core/urte_out_if.sv
// ----------------------------------------------------------------------------
// urte_out_if
// Result channel: transmit bytes and finished-transaction reports.
// ----------------------------------------------------------------------------
interface urte_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [15:0] read_data;
  logic        status;

  modport source (output valid, kind, tx_byte, last, read_data, status,
                  input ready);
  modport sink   (input valid, kind, tx_byte, last, read_data, status,
                  output ready);
endinterface

FILE: rtl/core/urte_front.sv
// ----------------------------------------------------------------------------
// urte_front
// Accepts input items, tracks the link protocol state and queues jobs.
// ----------------------------------------------------------------------------
module urte_front (
  input  logic             clk,
  input  logic             rst_n,
  urte_in_if.sink          in_chan,
  input  urte_pkg::q_stat_t q_stat,
  output logic             push,
  output urte_pkg::job_t   push_job
);
  import urte_pkg::*;

  logic       busy_r,   busy_nxt;
  logic       pend_rd_r, pend_rd_nxt;
  logic [1:0] seen_r,   seen_nxt;
  logic [7:0] hi_r,     hi_nxt;
  logic [7:0] lo_r,     lo_nxt;
  logic [7:0] sent_r,   sent_nxt;

  logic       acc;
  logic [7:0] faddr;
  logic [7:0] fchk;
  logic [7:0] rsum;

  assign in_chan.ready = !q_stat.full;
  assign acc   = in_chan.valid && in_chan.ready;
  assign faddr = {in_chan.is_read, in_chan.reg_address};
  assign fchk  = in_chan.is_read ? faddr
               : 8'(in_chan.write_value[15:8] + in_chan.write_value[7:0] + faddr);
  assign rsum  = 8'(hi_r + lo_r);

  // Classify the transaction and work out the next protocol state
  always_comb begin
    busy_nxt    = busy_r;
    pend_rd_nxt = pend_rd_r;
    seen_nxt    = seen_r;
    hi_nxt      = hi_r;
    lo_nxt      = lo_r;
    sent_nxt    = sent_r;
    push        = 1'b0;
    push_job    = '0;
    push_job.read_data = FAIL_DATA;
    if (acc) begin
      if (in_chan.op == OP_CMD) begin
        push             = 1'b1;
        push_job.kind    = JOB_FRAME;
        push_job.is_read = in_chan.is_read;
        push_job.addr    = faddr;
        push_job.hi      = in_chan.write_value[15:8];
        push_job.lo      = in_chan.write_value[7:0];
        push_job.chk     = fchk;
        busy_nxt    = 1'b1;
        pend_rd_nxt = in_chan.is_read;
        seen_nxt    = 2'd0;
        hi_nxt      = 8'h00;
        lo_nxt      = 8'h00;
        sent_nxt    = fchk;
      end else if (busy_r) begin
        if (!pend_rd_r) begin
          // write echo
          push            = 1'b1;
          push_job.kind   = JOB_DONE;
          push_job.status = (in_chan.rx_byte != sent_r) ? STAT_FAIL : STAT_OK;
          busy_nxt = 1'b0;
          seen_nxt = 2'd0;
        end else if (seen_r == 2'd0) begin
          hi_nxt   = in_chan.rx_byte;
          seen_nxt = 2'd1;
        end else if (seen_r == 2'd1) begin
          lo_nxt   = in_chan.rx_byte;
          seen_nxt = 2'd2;
        end else begin
          // read checksum byte closes the reply
          push          = 1'b1;
          push_job.kind = JOB_DONE;
          if (in_chan.rx_byte == rsum) begin
            push_job.read_data = {hi_r, lo_r};
            push_job.status    = STAT_OK;
          end else begin
            push_job.status    = STAT_FAIL;
          end
          busy_nxt = 1'b0;
          seen_nxt = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      pend_rd_r <= 1'b0;
      seen_r    <= 2'd0;
      hi_r      <= 8'h00;
      lo_r      <= 8'h00;
      sent_r    <= 8'h00;
    end else begin
      busy_r    <= busy_nxt;
      pend_rd_r <= pend_rd_nxt;
      seen_r    <= seen_nxt;
      hi_r      <= hi_nxt;
      lo_r      <= lo_nxt;
      sent_r    <= sent_nxt;
    end
  end

endmodule

FILE: rtl/core/urte_queue.sv
// ----------------------------------------------------------------------------
// urte_queue
// Short job queue between front and back; head visible without a pop.
// ----------------------------------------------------------------------------
module urte_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  urte_pkg::job_t    push_job,
  input  logic              pop,
  output urte_pkg::job_t    head_job,
  output urte_pkg::q_stat_t q_stat
);
  import urte_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QCW-1:0] cnt_r;

  assign head_job     = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == QCW'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.count = cnt_r;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/urte_back.sv
// ----------------------------------------------------------------------------
// urte_back
// Walks each queued job and drives one result per cycle into the output
// register while the output is not stalled.
// ----------------------------------------------------------------------------
module urte_back (
  input  logic              clk,
  input  logic              rst_n,
  input  urte_pkg::job_t    head_job,
  input  urte_pkg::q_stat_t q_stat,
  output logic              pop,
  urte_out_if.source        out_chan
);
  import urte_pkg::*;

  typedef enum logic [2:0] {
    S_SYNC,
    S_ADDR,
    S_HI,
    S_LO,
    S_CHK
  } step_t;

  step_t       step_r;
  step_t       step_nxt;
  logic        out_valid_r;
  logic        kind_r;
  logic [7:0]  tx_byte_r;
  logic        last_r;
  logic [15:0] read_data_r;
  logic        status_r;

  logic        adv;
  logic        res_kind;
  logic [7:0]  res_byte;
  logic        res_last;
  logic [15:0] res_data;
  logic        res_status;

  assign adv = !out_valid_r || out_chan.ready;
  assign pop = adv && !q_stat.empty && res_last;

  // Result for the current step of the head job
  always_comb begin
    res_kind   = KIND_TX;
    res_byte   = 8'h00;
    res_last   = 1'b0;
    res_data   = 16'h0000;
    res_status = STAT_OK;
    step_nxt   = step_r;
    if (head_job.kind == JOB_DONE) begin
      res_kind   = KIND_DONE;
      res_last   = 1'b1;
      res_data   = head_job.read_data;
      res_status = head_job.status;
      step_nxt   = S_SYNC;
    end else begin
      case (step_r)
        S_SYNC: begin
          res_byte = SYNC_BYTE;
          step_nxt = S_ADDR;
        end
        S_ADDR: begin
          res_byte = head_job.addr;
          step_nxt = head_job.is_read ? S_CHK : S_HI;
        end
        S_HI: begin
          res_byte = head_job.hi;
          step_nxt = S_LO;
        end
        S_LO: begin
          res_byte = head_job.lo;
          step_nxt = S_CHK;
        end
        S_CHK: begin
          res_byte = head_job.chk;
          res_last = 1'b1;
          step_nxt = S_SYNC;
        end
        default: begin
          res_byte = SYNC_BYTE;
          step_nxt = S_SYNC;
        end
      endcase
    end
  end

  // Step sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_SYNC;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (!q_stat.empty) begin
        out_valid_r <= 1'b1;
        step_r      <= step_nxt;
        kind_r      <= res_kind;
        tx_byte_r   <= res_byte;
        last_r      <= res_last;
        read_data_r <= res_data;
        status_r    <= res_status;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.kind      = kind_r;
  assign out_chan.tx_byte   = tx_byte_r;
  assign out_chan.last      = last_r;
  assign out_chan.read_data = read_data_r;
  assign out_chan.status    = status_r;

endmodule

FILE: rtl/core/uart_register_transaction_engine_core.sv
// ----------------------------------------------------------------------------
// uart_register_transaction_engine_core
// Host-side engine for a byte-framed register link: builds request frames
// and checks replies.
// ----------------------------------------------------------------------------
//  channel   direction  handshake     payload
//  in_chan   sink       valid/ready   op, is_read, reg_address, write_value,
//                                     rx_byte
//  out_chan  source     valid/ready   kind, tx_byte, last, read_data, status
//
//  The front takes one transaction per cycle while the job queue has room.
//  The back emits one result per cycle unless stalled; its step sequencer runs
//  sync addr hi lo chk for a write, sync addr chk for a read, or a report.
//  Reset (rst_n low, synchronous) empties the queue and returns to idle.
//  A stalled output holds its result; the queue (4 jobs) keeps input moving.
// ----------------------------------------------------------------------------
module uart_register_transaction_engine_core (
  input  logic       clk,
  input  logic       rst_n,
  urte_in_if.sink    in_chan,
  urte_out_if.source out_chan
);
  import urte_pkg::*;

  logic    push;
  logic    pop;
  job_t    push_job;
  job_t    head_job;
  q_stat_t q_stat;

  urte_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  urte_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  urte_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

  // Queue never overfills and never pops when empty
  a_q_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.count <= QCW'(QDEPTH)) && !(pop && q_stat.empty))
    else $error("job queue count out of range");

  // A push is only made when the queue had room
  a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full job queue");

  // A finished report is always the last result of its transaction
  a_done_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.kind == KIND_DONE) |-> out_chan.last)
    else $error("finished result without last");

  // A popped job leaves the output register with its last result next cycle
  a_pop_last : assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_chan.valid && out_chan.last))
    else $error("job popped without its last result");

endmodule
